// ===== sv/etpb_pkg.sv =====
// ----------------------------------------------------------------------------
// Elimination tree parent builder package
// Shared widths, defaults, operation codes and the ancestor entry type.
// ----------------------------------------------------------------------------
package etpb_pkg;

  // Width of a node position in the edge and pair words.
  localparam int unsigned FIELD_W = 10;

  // Default size of the ancestor store.
  localparam int unsigned MAX_NODES_DEF = 1024;

  // Operation codes carried in the op field of an edge word.
  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // One ancestor store entry: a valid flag and the ancestor's position.
  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] node;
  } anc_entry_t;

endpackage

// ===== sv/etpb_if.sv =====
// ----------------------------------------------------------------------------
// Elimination tree parent builder channels
// Valid/ready channels for edge words in and child/parent words out.
// ----------------------------------------------------------------------------
interface etpb_in_if
  import etpb_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               op;
  logic [FIELD_W-1:0] column;
  logic [FIELD_W-1:0] neighbor;

  modport source (output valid, output op, output column, output neighbor, input ready);
  modport sink   (input valid, input op, input column, input neighbor, output ready);
endinterface

interface etpb_out_if
  import etpb_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] child;
  logic [FIELD_W-1:0] parent;

  modport source (output valid, output child, output parent, input ready);
  modport sink   (input valid, input child, input parent, output ready);
endinterface

// ===== sv/etpb_ram.sv =====
// ----------------------------------------------------------------------------
// Ancestor store
// Single-write, single-read synchronous memory with a registered read port;
// a read of the entry written in the same cycle returns new data.
// ----------------------------------------------------------------------------
module etpb_ram
  import etpb_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF,
  localparam int unsigned AW = $clog2(MAX_NODES)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  anc_entry_t    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output anc_entry_t    rdata_o
);

  anc_entry_t store_q [MAX_NODES];
  anc_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
  end

  // Write-first forwarding covers a chain that loops back onto its own entry.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= store_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/etpb_walker.sv =====
// ----------------------------------------------------------------------------
// Ancestor chain walker
// Takes edge words, chases and compresses the ancestor chain in the store,
// sweeps the store on clear and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module etpb_walker
  import etpb_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF,
  localparam int unsigned AW = $clog2(MAX_NODES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  etpb_in_if.sink       in_i,
  etpb_out_if.source    out_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output anc_entry_t    mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o,
  input  anc_entry_t    mem_rdata_i
);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_WALK,
    ST_HOLD
  } state_e;

  state_e             state_q, state_d;
  logic [AW-1:0]      sweep_q, sweep_d;
  logic [AW-1:0]      cur_q, cur_d;
  logic [FIELD_W-1:0] col_q, col_d;
  logic               out_valid_q, out_valid_d;
  logic [FIELD_W-1:0] child_q, child_d;
  logic [FIELD_W-1:0] parent_q, parent_d;

  logic                  in_fire;
  logic                  edge_ok;
  logic                  slot_free;
  logic [AW+FIELD_W-1:0] nb_wide;
  logic [AW+FIELD_W-1:0] node_wide;
  logic [AW+FIELD_W-1:0] cur_wide;

  // Positions are widened before they are cut to the address width, so the
  // same code serves stores smaller and larger than the field range.
  assign nb_wide   = {{AW{1'b0}}, in_i.neighbor};
  assign node_wide = {{AW{1'b0}}, mem_rdata_i.node};
  assign cur_wide  = {{FIELD_W{1'b0}}, cur_q};

  assign in_fire   = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign edge_ok   = (32'(in_i.column) < MAX_NODES) && (32'(in_i.neighbor) < MAX_NODES)
                     && (in_i.neighbor < in_i.column);

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    cur_d       = cur_q;
    col_d       = col_q;
    out_valid_d = out_valid_q && !out_o.ready;
    child_d     = child_q;
    parent_d    = parent_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = cur_q;
    mem_wdata_o = '{valid: 1'b1, node: col_q};
    mem_re_o    = 1'b0;
    mem_raddr_o = nb_wide[AW-1:0];

    unique case (state_q)
      ST_SWEEP: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = sweep_q;
        mem_wdata_o = '0;
        sweep_d     = sweep_q + AW'(1);
        if (sweep_q == AW'(MAX_NODES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.op == OP_CLEAR) begin
            sweep_d = '0;
            state_d = ST_SWEEP;
          end else if (edge_ok) begin
            mem_re_o = 1'b1;
            cur_d    = nb_wide[AW-1:0];
            col_d    = in_i.column;
            state_d  = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (mem_rdata_i.valid && (mem_rdata_i.node != col_q)) begin
          // Repoint the visited entry at the column and follow its ancestor.
          mem_we_o    = 1'b1;
          mem_re_o    = 1'b1;
          mem_raddr_o = node_wide[AW-1:0];
          cur_d       = node_wide[AW-1:0];
        end else if (mem_rdata_i.valid) begin
          state_d = ST_IDLE;
        end else begin
          // A root: it becomes a child of the column. The pair register is
          // only loaded once the previous word has left it.
          mem_we_o = 1'b1;
          if (slot_free) begin
            child_d     = cur_wide[FIELD_W-1:0];
            parent_d    = col_q;
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          child_d     = cur_wide[FIELD_W-1:0];
          parent_d    = col_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    col_q    <= col_d;
    child_q  <= child_d;
    parent_q <= parent_d;
  end

  assign in_i.ready   = (state_q == ST_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.child  = child_q;
  assign out_o.parent = parent_q;

endmodule

// ===== sv/elimination_tree_parent_builder_top.sv =====
// ----------------------------------------------------------------------------
// Elimination tree parent builder
// Builds elimination tree parents from a stream of edge words by walking and
// compressing ancestor chains held in a synchronous memory.
// ----------------------------------------------------------------------------
// Flow: an edge word is taken only in the idle state; its walk issues one
//   store read per chain step, and the pair word is registered once a root
//   is reached. The next edge word is taken only after the walk ends.
// An ignored edge word leaves the walker idle; a new pair waits until the last is taken.
// Reset and clear: every store entry is swept, one entry a cycle, and no
//   edge word is taken during the sweep.
module elimination_tree_parent_builder_top
  import etpb_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  etpb_in_if.sink    in_i,
  etpb_out_if.source out_o
);

  localparam int unsigned AW = $clog2(MAX_NODES);

  // Memory port between the walker and the ancestor store. The walker issues
  // a read in the cycle it takes an edge word and, while the chain goes on,
  // writes the visited entry back pointing at the column and reads the next
  // one in the same cycle. The store forwards a write to a read of the same
  // entry, so a chain that closes on itself is seen correctly.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  anc_entry_t    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  anc_entry_t    mem_rdata;

  // Chain walker: handshakes, the sweep after reset and clear, and the result
  // register that lets a pair word wait while new edges are taken, until the next pair needs it.
  etpb_walker #(
    .MAX_NODES (MAX_NODES)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Ancestor store: one entry for each node position.
  etpb_ram #(
    .MAX_NODES (MAX_NODES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== sv/etpb_checker.sv =====
// ----------------------------------------------------------------------------
// Elimination tree parent builder checker
// Port-level assertions on handshakes, latency and the clearing sweep.
// ----------------------------------------------------------------------------
module etpb_checker
  import etpb_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_op_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [FIELD_W-1:0] out_child_i,
  input logic [FIELD_W-1:0] out_parent_i
);

  // A waiting pair word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("pair word withdrawn while stalled");

  // A waiting pair word keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_child_i) && $stable(out_parent_i))
    else $error("pair word changed while stalled");

  // No result can appear in the cycle right after an edge word is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("pair word faster than the memory read");

  // A clear starts the sweep, so no word is taken in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_op_i == OP_CLEAR) |=> !in_ready_i)
    else $error("edge word taken during the clearing sweep");

endmodule

bind elimination_tree_parent_builder_top etpb_checker u_etpb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_op_i      (in_i.op),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_child_i  (out_o.child),
  .out_parent_i (out_o.parent)
);

// ===== sim/elimination_tree_parent_builder_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Elimination tree parent builder testbench
// Streams edge words into the builder and checks every child/parent word it
// returns against a behavioural copy of the ancestor store. The run starts
// with hand-picked edges and clears, then moves on to random matrix phases.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module elimination_tree_parent_builder_top_tb;
  import etpb_pkg::*;

  localparam int unsigned TREE_NODES  = MAX_NODES_DEF;
  localparam int unsigned EDGE_TARGET = 450;
  localparam int unsigned MAX_GAP     = 12;
  localparam int unsigned MAX_REPORTS = 10;

  // One edge word waiting to be sent, with the idle time that precedes it.
  // A word marked drain is held back until every expected pair has arrived.
  typedef struct {
    logic               op;
    logic [FIELD_W-1:0] column;
    logic [FIELD_W-1:0] neighbor;
    int unsigned        gap;
    bit                 drain;
  } edge_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] child;
    logic [FIELD_W-1:0] parent;
  } tree_pair_t;

  logic clk_i;
  logic rst_ni;

  etpb_in_if  in_ch ();
  etpb_out_if out_ch ();

  elimination_tree_parent_builder_top #(
    .MAX_NODES(TREE_NODES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Our own copy of the ancestor store, updated as each edge word is taken.
  anc_entry_t   ancestor_links [TREE_NODES];
  edge_word_t   pending_words[$];
  tree_pair_t   expected_pairs[$];

  int unsigned  mismatches;
  int unsigned  edge_count;
  bit           quiet_source;
  bit           quiet_sink;

  // Driver state.
  edge_word_t   cur_word;
  bit           staged;
  bit           holding;
  bit           word_taken;
  int unsigned  gap_left;

  // Monitor state.
  bit           pair_taken;
  int unsigned  stall_left;

  always #1 clk_i = ~clk_i;

  // Liu's rule with path compression. Every entry met on the walk up from the
  // neighbour is pointed at the column; a root reached this way gains the
  // column as its parent and is reported. Returns 1 when a pair results.
  function automatic bit link_edge(input logic op, input logic [FIELD_W-1:0] column,
                                   input logic [FIELD_W-1:0] neighbor,
                                   output tree_pair_t pair);
    logic [FIELD_W-1:0] node;
    logic [FIELD_W-1:0] next_node;
    int unsigned        steps;
    node  = neighbor;
    steps = 0;
    pair  = '0;
    if (op == OP_CLEAR) begin
      foreach (ancestor_links[i]) ancestor_links[i] = '0;
      return 1'b0;
    end
    if (column >= TREE_NODES || neighbor >= TREE_NODES) return 1'b0;
    // Only neighbours below the column take part.
    if (neighbor >= column) return 1'b0;
    while (ancestor_links[node].valid && ancestor_links[node].node != column) begin
      next_node = ancestor_links[node].node;
      // The walk is capped, which only matters when columns arrive out of order.
      if (steps >= TREE_NODES || next_node >= TREE_NODES) return 1'b0;
      ancestor_links[node].node = column;
      node  = next_node;
      steps++;
    end
    // Reaching an entry that already points at the column means this subtree
    // is attached already.
    if (ancestor_links[node].valid) return 1'b0;
    ancestor_links[node].valid = 1'b1;
    ancestor_links[node].node  = column;
    pair.child  = node;
    pair.parent = column;
    return 1'b1;
  endfunction

  task automatic queue_word(input logic op, input int unsigned column,
                            input int unsigned neighbor, input bit drain);
    edge_word_t w;
    w.op       = op;
    w.column   = column[FIELD_W-1:0];
    w.neighbor = neighbor[FIELD_W-1:0];
    w.gap      = quiet_source ? 0 : $urandom_range(0, MAX_GAP);
    w.drain    = drain;
    pending_words.insert(pending_words.size(), w);
    edge_count++;
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: mismatch: %s", $realtime, what);
  endtask

  // All acceptance is judged at the rising edge. Prediction comes first so
  // that an expectation is always queued before a word could be compared
  // against it, whatever the order of the blocks within the time step.
  always @(posedge clk_i) begin
    tree_pair_t pair;
    tree_pair_t seen;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        if (link_edge(in_ch.op, in_ch.column, in_ch.neighbor, pair))
          expected_pairs.insert(expected_pairs.size(), pair);
        word_taken = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        seen.child  = out_ch.child;
        seen.parent = out_ch.parent;
        if (expected_pairs.size() == 0) begin
          report_mismatch($sformatf("unexpected word child %0d parent %0d",
                                    seen.child, seen.parent));
        end else begin
          pair = expected_pairs.pop_front();
          if (seen.child !== pair.child || seen.parent !== pair.parent)
            report_mismatch($sformatf("expected child %0d parent %0d, got child %0d parent %0d",
                                      pair.child, pair.parent, seen.child, seen.parent));
        end
        pair_taken = 1'b1;
      end
    end
  end

  // Driver: takes the next edge word from the queue, waits out its gap and
  // then holds it until the builder accepts it. Inputs move on the falling
  // edge only, and valid gets a single assignment per edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (word_taken) begin
        word_taken = 1'b0;
        holding    = 1'b0;
      end
      if (!holding && !staged && pending_words.size() > 0 &&
          (!pending_words[0].drain || expected_pairs.size() == 0)) begin
        cur_word = pending_words.pop_front();
        staged   = 1'b1;
        gap_left = cur_word.gap;
      end
      if (staged && !holding) begin
        if (gap_left == 0) begin
          staged  = 1'b0;
          holding = 1'b1;
        end else begin
          gap_left--;
        end
      end
      in_ch.valid    <= holding;
      in_ch.op       <= cur_word.op;
      in_ch.column   <= cur_word.column;
      in_ch.neighbor <= cur_word.neighbor;
    end
  end

  // Monitor back-pressure: after each accepted pair word a fresh stall is
  // drawn. Now and then the sink switches to a stall-free stretch.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pair_taken) begin
        pair_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) quiet_sink = !quiet_sink;
        stall_left = quiet_sink ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: far beyond even a run made entirely of clears with full stalls.
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned nodes;
    int unsigned base;
    int unsigned fan;
    int unsigned pick;
    int unsigned col;
    int unsigned nb;
    bit          first;

    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_EDGE;
    in_ch.column   = '0;
    in_ch.neighbor = '0;
    out_ch.ready   = 1'b0;
    mismatches     = 0;
    edge_count     = 0;
    quiet_source   = 1'b0;
    quiet_sink     = 1'b0;
    staged         = 1'b0;
    holding        = 1'b0;
    word_taken     = 1'b0;
    gap_left       = 0;
    pair_taken     = 1'b0;
    stall_left     = 0;
    cur_word       = '{op: OP_EDGE, column: '0, neighbor: '0, gap: 0, drain: 1'b0};
    foreach (ancestor_links[i]) ancestor_links[i] = '0;

    // Directed part. A clear with every field bit set, the ignored cases, a
    // chain that has to be walked and compressed, the top of the range, and
    // a column that arrives out of order and grafts an older root below it.
    queue_word(OP_CLEAR, 1023, 1023, 1'b0);
    queue_word(OP_EDGE,     0,    0, 1'b0);   // neighbour equal to column
    queue_word(OP_EDGE,     0, 1023, 1'b0);   // neighbour above column
    queue_word(OP_EDGE,     1,    0, 1'b0);   // 0 joins 1
    queue_word(OP_EDGE,     2,    0, 1'b0);   // walk 0 -> 1, 1 joins 2
    queue_word(OP_EDGE,     2,    1, 1'b0);   // already under 2, nothing new
    queue_word(OP_EDGE,     3,    3, 1'b0);
    queue_word(OP_EDGE,     3,    1, 1'b0);   // 2 joins 3
    queue_word(OP_EDGE,  1023, 1022, 1'b0);
    queue_word(OP_EDGE,  1023,    0, 1'b0);   // compressed path reaches 3
    queue_word(OP_EDGE,  1023, 1023, 1'b0);
    queue_word(OP_EDGE,     5,    4, 1'b0);
    queue_word(OP_EDGE,     4,    1, 1'b0);   // out of order: 1023 joins 4
    queue_word(OP_EDGE,     6, 1022, 1'b0);   // long chain up to root 5
    queue_word(OP_EDGE,  1000,  999, 1'b0);
    queue_word(OP_CLEAR,    0,    0, 1'b1);   // clear with the pipeline drained
    queue_word(OP_EDGE,     1,    0, 1'b0);   // store must be empty again
    queue_word(OP_EDGE,   512,  511, 1'b0);
    queue_word(OP_EDGE,   682,  341, 1'b0);   // alternating bit patterns
    queue_word(OP_EDGE,   341,  682, 1'b0);

    // Random part: each phase is a small matrix placed somewhere in the
    // position range, its columns in order with a few neighbours each, and a
    // sprinkling of noise, reversed columns and neighbours that are ignored.
    first = 1'b1;
    while (edge_count < EDGE_TARGET) begin
      quiet_source = ($urandom_range(0, 3) == 0);
      if (first || $urandom_range(0, 3) != 0)
        queue_word(OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
                   first || $urandom_range(0, 2) == 0);
      first = 1'b0;
      nodes = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(4, 40);
      base  = $urandom_range(0, TREE_NODES - nodes);
      for (int unsigned c = 1; c < nodes && edge_count < EDGE_TARGET; c++) begin
        fan = $urandom_range(0, 3);
        repeat (fan) begin
          pick = $urandom_range(0, 19);
          if (pick == 0) begin
            col = $urandom_range(0, 1023);
            nb  = $urandom_range(0, 1023);
          end else if (pick == 1) begin
            col = base + $urandom_range(1, c);
            nb  = base + $urandom_range(0, col - base - 1);
          end else if (pick == 2) begin
            col = base + c;
            nb  = base + $urandom_range(c, nodes - 1);
          end else begin
            col = base + c;
            nb  = base + $urandom_range(0, c - 1);
          end
          queue_word(OP_EDGE, col, nb, 1'b0);
        end
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_words.size() > 0 || staged || holding) @(posedge clk_i);
    while (expected_pairs.size() > 0) @(posedge clk_i);
    // Let any stray word show itself before the verdict.
    repeat (64) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/etpb_pkg.sv
sv/etpb_if.sv
sv/etpb_ram.sv
sv/etpb_walker.sv
sv/elimination_tree_parent_builder_top.sv
sv/etpb_checker.sv
sim/elimination_tree_parent_builder_top_tb.sv
